/* sv/fcca_pkg.sv */
// Shared types and constants for the FAT cluster chain allocator.
package fcca_pkg;
   localparam int unsigned MaxClusters = 1024;
   localparam int unsigned IdxW = $clog2(MaxClusters);

   localparam logic [31:0] LinkMask   = 32'h0FFF_FFFF;
   localparam logic [31:0] MarkEnd    = 32'h0FFF_FFFF;
   localparam logic [31:0] MarkEndMin = 32'h0FFF_FFF8;
   localparam logic [31:0] MarkMedia  = 32'h0FFF_FFF8;

   localparam logic [1:0] StOk     = 2'd0;
   localparam logic [1:0] StFull   = 2'd1;
   localparam logic [1:0] StBroken = 2'd2;

   typedef enum logic [2:0] {
      OP_ALLOC  = 3'd0,
      OP_APPEND = 3'd1,
      OP_LENGTH = 3'd2,
      OP_SETEND = 3'd3,
      OP_SETFREE = 3'd4,
      OP_FREECNT = 3'd5,
      OP_WRITE  = 3'd6,
      OP_READ   = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD,
      S_WAIT,
      S_EXEC,
      S_DONE
   } state_type;

   function automatic logic is_end(input logic [31:0] e);
      return (e & LinkMask) >= MarkEndMin;
   endfunction

   function automatic logic is_free(input logic [31:0] e);
      return (e & LinkMask) == 32'd0;
   endfunction
endpackage

/* sv/fcca_ram.sv */
// Generic single-port RAM with registered read.
module fcca_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* sv/fat_cluster_chain_allocator.sv */
// Top level: FAT table sequencer with next-fit allocation and chain walks.
// Each transaction runs on one shared table port, one entry read at a time.
// After reset the table is cleared by a pass over every entry before the first
// request is taken. An allocation or free count reads each entry it visits
// (up to cluster_count per scan) and an allocation writes each cluster taken,
// a chain walk reads one link at a time, and raw reads and writes touch one entry. One
// transaction is handled at a time; the next request waits until the response
// has been taken.
module fat_cluster_chain_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [9:0]  req_cluster,
   input  logic [9:0]  req_count,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);
   localparam int unsigned IW = fcca_pkg::IdxW;

   fcca_pkg::state_type state_ff, state_in;
   fcca_pkg::op_type    op_ff, op_in;
   logic [10:0] ccount_ff;
   logic [IW-1:0] cursor_ff, cursor_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic [IW:0]   pos_ff, pos_in;      // walk steps
   logic [IW:0]   left_ff, left_in;    // clusters still to allocate
   logic [IW-1:0] prev_ff, prev_in;
   logic          have_ff, have_in;    // at least one cluster taken
   logic          wrap_ff, wrap_in;    // second half of next-fit scan
   logic [IW:0]   len_ff, len_in;
   logic [31:0]   value_ff, value_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   result_ff, result_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          link_ff, link_in;    // pending link write of prev
   logic [IW:0]   neff;
   logic [IW:0]   top;

   logic          wr_en;
   logic [IW-1:0] ram_addr;
   logic [31:0]   wr_data, rd_data;

   fcca_ram #(.Width(32), .Depth(fcca_pkg::MaxClusters)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (ram_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign neff = (ccount_ff > 11'(fcca_pkg::MaxClusters)) ?
                 (IW+1)'(fcca_pkg::MaxClusters) : (IW+1)'(ccount_ff);
   assign top  = ({1'b0, cursor_ff} < neff) ? {1'b0, cursor_ff} :
                 (neff == '0) ? '0 : neff - 1'b1;

   assign req_ready  = (state_ff == fcca_pkg::S_IDLE) && !rsp_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcca_pkg::S_CLEAR;
         ccount_ff    <= 11'd1024;
         cursor_ff    <= IW'(1);
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
         link_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
         link_ff      <= link_in;
         if (csr_wr_en) begin
            ccount_ff <= csr_wr_data;
         end
      end
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      left_ff   <= left_in;
      prev_ff   <= prev_in;
      have_ff   <= have_in;
      wrap_ff   <= wrap_in;
      len_ff    <= len_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   // sequencer
   always_comb begin
      logic [IW:0] nxt;
      logic [31:0] lk;
      state_in = state_ff;
      op_in = op_ff;  cursor_in = cursor_ff;  addr_in = addr_ff;
      pos_in = pos_ff;  left_in = left_ff;  prev_in = prev_ff;
      have_in = have_ff;  wrap_in = wrap_ff;  len_in = len_ff;
      value_in = value_ff;  status_in = status_ff;  result_in = result_ff;
      link_in = link_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      nxt = '0;  lk = rd_data & fcca_pkg::LinkMask;
      case (state_ff)
         fcca_pkg::S_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == IW'(fcca_pkg::MaxClusters - 1)) begin
               state_in = fcca_pkg::S_IDLE;
            end
         end
         fcca_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = fcca_pkg::op_type'(req_op);
               value_in = req_value;
               status_in = fcca_pkg::StOk;
               result_in = '0;
               addr_in = req_cluster;
               have_in = 1'b0;
               link_in = 1'b0;
               len_in = '0;
               pos_in = '0;
               wrap_in = 1'b0;
               left_in = (req_count == 10'd0) ? (IW+1)'(1) : (IW+1)'(req_count);
               state_in = fcca_pkg::S_RD;
               case (fcca_pkg::op_type'(req_op))
                  fcca_pkg::OP_ALLOC: begin
                     nxt = {1'b0, cursor_ff} + 1'b1;
                     if (nxt < neff) begin
                        addr_in = nxt[IW-1:0];
                     end else begin
                        wrap_in = 1'b1;
                        addr_in = IW'(2);
                        if ((IW+1)'(2) > top) begin
                           status_in = fcca_pkg::StFull;
                           state_in = fcca_pkg::S_DONE;
                        end
                     end
                  end
                  fcca_pkg::OP_APPEND, fcca_pkg::OP_LENGTH: begin
                     if ({1'b0, req_cluster} >= neff) begin
                        status_in = fcca_pkg::StBroken;
                        state_in = fcca_pkg::S_DONE;
                     end else begin
                        len_in = (IW+1)'(1);
                     end
                  end
                  fcca_pkg::OP_FREECNT: begin
                     addr_in = IW'(2);
                     if (neff <= (IW+1)'(2)) begin
                        state_in = fcca_pkg::S_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         fcca_pkg::S_RD: begin
            state_in = fcca_pkg::S_WAIT;
            case (op_ff)
               fcca_pkg::OP_SETEND, fcca_pkg::OP_SETFREE, fcca_pkg::OP_WRITE: begin
                  state_in = fcca_pkg::S_DONE;
               end
               default: ;
            endcase
         end
         fcca_pkg::S_WAIT: begin
            state_in = fcca_pkg::S_EXEC;
         end
         fcca_pkg::S_EXEC: begin
            state_in = fcca_pkg::S_RD;
            case (op_ff)
               fcca_pkg::OP_READ: begin
                  result_in = rd_data;
                  state_in = fcca_pkg::S_DONE;
               end
               fcca_pkg::OP_FREECNT: begin
                  if (fcca_pkg::is_free(rd_data)) begin
                     result_in = result_ff + 1'b1;
                  end
                  addr_in = addr_ff + 1'b1;
                  if ({1'b0, addr_ff} + 1'b1 >= neff) begin
                     state_in = fcca_pkg::S_DONE;
                  end
               end
               fcca_pkg::OP_APPEND, fcca_pkg::OP_LENGTH: begin
                  result_in = 32'(len_ff);
                  if (fcca_pkg::is_end(rd_data)) begin
                     if (op_ff == fcca_pkg::OP_APPEND) begin
                        result_in = 32'(addr_ff);
                     end
                     state_in = fcca_pkg::S_DONE;
                  end else if (pos_ff >= neff || lk < 32'd2 || lk >= 32'(neff)) begin
                     status_in = fcca_pkg::StBroken;
                     if (op_ff == fcca_pkg::OP_APPEND) begin
                        result_in = '0;
                     end
                     state_in = fcca_pkg::S_DONE;
                  end else begin
                     addr_in = lk[IW-1:0];
                     len_in = len_ff + 1'b1;
                     pos_in = pos_ff + 1'b1;
                  end
               end
               fcca_pkg::OP_ALLOC: begin
                  if (link_ff) begin
                     // second step of a take: link previous to this one
                     link_in = 1'b0;
                     prev_in = addr_ff;
                     state_in = fcca_pkg::S_EXEC;
                     if (left_ff == (IW+1)'(1)) begin
                        state_in = fcca_pkg::S_DONE;
                     end else begin
                        left_in = left_ff - 1'b1;
                        nxt = {1'b0, addr_ff} + 1'b1;
                        wrap_in = 1'b0;
                        if (nxt < neff) begin
                           addr_in = nxt[IW-1:0];
                           state_in = fcca_pkg::S_RD;
                        end else begin
                           wrap_in = 1'b1;
                           addr_in = IW'(2);
                           state_in = fcca_pkg::S_RD;
                           if ((IW+1)'(2) > ({1'b0, addr_ff} < neff ?
                               {1'b0, addr_ff} : neff - 1'b1)) begin
                              status_in = fcca_pkg::StFull;
                              state_in = fcca_pkg::S_DONE;
                           end
                        end
                     end
                  end else if (fcca_pkg::is_free(rd_data)) begin
                     cursor_in = addr_ff;
                     link_in = 1'b1;
                     state_in = fcca_pkg::S_EXEC;
                     if (!have_ff) begin
                        have_in = 1'b1;
                        result_in = 32'(addr_ff);
                        prev_in = addr_ff;
                     end
                  end else begin
                     nxt = {1'b0, addr_ff} + 1'b1;
                     if (!wrap_ff) begin
                        if (nxt < neff) begin
                           addr_in = nxt[IW-1:0];
                        end else begin
                           wrap_in = 1'b1;
                           addr_in = IW'(2);
                           if ((IW+1)'(2) > top) begin
                              status_in = fcca_pkg::StFull;
                              state_in = fcca_pkg::S_DONE;
                           end
                        end
                     end else begin
                        addr_in = nxt[IW-1:0];
                        if (nxt > top) begin
                           status_in = fcca_pkg::StFull;
                           state_in = fcca_pkg::S_DONE;
                        end
                     end
                  end
               end
               default: state_in = fcca_pkg::S_DONE;
            endcase
         end
         fcca_pkg::S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = fcca_pkg::S_IDLE;
         end
         default: state_in = fcca_pkg::S_IDLE;
      endcase
   end

   // table port
   always_comb begin
      wr_en = 1'b0;  ram_addr = addr_ff;  wr_data = '0;
      case (state_ff)
         fcca_pkg::S_CLEAR: begin
            wr_en = 1'b1;
            wr_data = (addr_ff == IW'(0)) ? fcca_pkg::MarkMedia :
                      (addr_ff == IW'(1)) ? fcca_pkg::MarkEnd : 32'd0;
         end
         fcca_pkg::S_RD: begin
            case (op_ff)
               fcca_pkg::OP_SETEND: begin
                  wr_en = 1'b1;  wr_data = fcca_pkg::MarkEnd;
               end
               fcca_pkg::OP_SETFREE: begin
                  wr_en = 1'b1;  wr_data = '0;
               end
               fcca_pkg::OP_WRITE: begin
                  wr_en = 1'b1;  wr_data = value_ff;
               end
               default: ;
            endcase
         end
         fcca_pkg::S_EXEC: begin
            case (op_ff)
               fcca_pkg::OP_APPEND: begin
                  if (fcca_pkg::is_end(rd_data)) begin
                     wr_en = 1'b1;  wr_data = value_ff;
                  end
               end
               fcca_pkg::OP_ALLOC: begin
                  if (link_ff) begin
                     // first cluster of a chain has no predecessor
                     wr_en = (prev_ff != addr_ff);
                     ram_addr = prev_ff;
                     wr_data = 32'(addr_ff);
                  end else if (fcca_pkg::is_free(rd_data)) begin
                     wr_en = 1'b1;  wr_data = fcca_pkg::MarkEnd;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("response dropped");

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> !req_ready;
   endproperty
   a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

   property p_status_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> rsp_status != 2'd3;
   endproperty
   a_status_range: assert property (p_status_range) else $error("bad status");
endmodule
